// ===== src/rbf_pkg.sv =====
// rbf_pkg: shared constants, types and exp table step ratio for the rbf torque estimator
// no dependencies
`default_nettype none
package rbf_pkg;

  localparam int JOINTS_DEF    = 6;
  localparam int CENTRES_DEF   = 5;
  localparam int EXP_DEPTH_DEF = 1024;
  localparam int EXP_RANGE     = 16;
  localparam int WIDTH_REGS    = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 18;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH0     = 3'd2;

  localparam logic [15:0] LEARN_RATE_RST = 16'd32768;
  localparam logic [15:0] MOMENTUM_RST   = 16'd3277;

  typedef logic [17:0] inv_width_t;
  typedef logic signed [31:0] q16_t;

  function automatic inv_width_t width_reset(input int j);
    inv_width_t r;
    unique case (j)
      0: r = 18'd8889;
      1: r = 18'd13998;
      2: r = 18'd17980;
      3: r = 18'd16024;
      4: r = 18'd18806;
      default: r = 18'd77557;
    endcase
    return r;
  endfunction

  // floor(n/d) for n >= 0, d > 0 by shift and subtract, elaboration time only
  function automatic longint udiv(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((n >>> b) & longint'(1));
      if (r >= d) begin
        r = r - d;
        q = q | (longint'(1) <<< b);
      end
    end
    return q;
  endfunction

  // round(n/d), half toward plus infinity, elaboration time only
  function automatic longint div_round(input longint n, input longint d);
    longint num;
    longint den;
    num = 2 * n + d;
    den = 2 * d;
    if (num >= 0) return udiv(num, den);
    return -udiv(-num + den - 1, den);
  endfunction

  function automatic longint shr_round(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // centre positions, Q15.16
  function automatic q16_t centre_pos(input int c);
    return q16_t'(div_round(longint'(2 * c - 5) * 1081344, 5));
  endfunction

  function automatic q16_t centre_vel(input int c);
    return q16_t'(div_round(longint'(c - 2) * 2162688, 25));
  endfunction

  // table step ratio exp(-range/depth) in Q30 from its series
  function automatic longint exp_ratio(input int depth);
    longint x;
    longint term;
    longint sum;
    x = div_round(longint'(EXP_RANGE) <<< 30, longint'(depth));
    term = longint'(1) <<< 30;
    sum = term;
    for (int n = 1; n <= 24; n++) begin
      term = shr_round(term * x, 30);
      term = div_round(term, longint'(n));
      sum = ((n & 1) == 1) ? sum - term : sum + term;
    end
    return sum;
  endfunction

endpackage
`default_nettype wire

// ===== src/rbf_stream_if.sv =====
// rbf_in_if / rbf_out_if: valid-ready channels of the estimator
// depends on nothing
`default_nettype none
interface rbf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  joint_index;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] target_torque;
  modport source (output valid, joint_index, position, velocity, target_torque, input ready);
  modport sink (input valid, joint_index, position, velocity, target_torque, output ready);
endinterface

interface rbf_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] estimate;
  logic [2:0]  joint_out;
  modport source (output valid, estimate, joint_out, input ready);
  modport sink (input valid, estimate, joint_out, output ready);
endinterface
`default_nettype wire

// ===== src/rbf_network_torque_estimator.sv =====
// rbf_network_torque_estimator: top level with sequencer, weight memory and shared multiplier
// depends on rbf_pkg, rbf_stream_if, rbf_exp_rom, rbf_mac
// sequencing: activations are computed centre by centre, then the weights of the joint are
//   updated centre by centre; the result is presented once the update pass is done
// throughput: a new transaction is taken only after the previous result is accepted, all
//   through the single shared multiplier; a joint out of range skips straight to the output
// reset: synchronous active-low rst_n restores registers; a clearing pass over every
//   word of the weight memory follows, while in.ready stays low
`default_nettype none
module rbf_network_torque_estimator #(
  parameter int JOINTS    = rbf_pkg::JOINTS_DEF,
  parameter int CENTRES   = rbf_pkg::CENTRES_DEF,
  parameter int EXP_DEPTH = rbf_pkg::EXP_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  rbf_in_if.sink                              in_ch,
  rbf_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [rbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rbf_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int NW    = JOINTS * CENTRES;
  localparam int AW    = (NW > 1) ? $clog2(NW) : 1;
  localparam int CW    = (CENTRES > 1) ? $clog2(CENTRES) : 1;
  localparam int EAW   = $clog2(EXP_DEPTH);
  localparam int IDXSH = 16 + $clog2(rbf_pkg::EXP_RANGE) - EAW;

  // sequencer states
  localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_DX = 5'd2,  S_DY = 5'd3,
                         S_SQX = 5'd4,  S_SQY = 5'd5,  S_ARG = 5'd6,  S_ARG2 = 5'd7,
                         S_ROM = 5'd8,  S_DOT = 5'd9,  S_DOT2 = 5'd10, S_EST = 5'd11,
                         S_ERR = 5'd12, S_ERR2 = 5'd13, S_UW = 5'd14, S_UDW = 5'd15,
                         S_UDW2 = 5'd16, S_UM = 5'd17, S_UM2 = 5'd18, S_UWR = 5'd19,
                         S_OUT = 5'd20, S_URD = 5'd21, S_ARG3 = 5'd22, S_RDW = 5'd23;

  logic [4:0] state_r, state_nxt;

  // configuration registers
  logic [15:0] learn_rate_r, momentum_r;
  rbf_pkg::inv_width_t inv_width_r [rbf_pkg::WIDTH_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r <= rbf_pkg::LEARN_RATE_RST;
      momentum_r   <= rbf_pkg::MOMENTUM_RST;
      for (int i = 0; i < rbf_pkg::WIDTH_REGS; i++) inv_width_r[i] <= rbf_pkg::width_reset(i);
    end else if (cfg_we) begin
      if (cfg_index == rbf_pkg::REG_LEARN_RATE) learn_rate_r <= cfg_data[15:0];
      else if (cfg_index == rbf_pkg::REG_MOMENTUM) momentum_r <= cfg_data[15:0];
      else inv_width_r[cfg_index - rbf_pkg::REG_WIDTH0] <= cfg_data;
    end
  end

  // item registers
  logic [2:0]         joint_r;
  logic signed [31:0] pos_r, vel_r, tgt_r;
  logic [AW-1:0]      base_r;
  logic [CW-1:0]      c_r;
  logic [AW-1:0]      clr_r;
  logic signed [32:0] dx_r, dy_r;
  logic [40:0]        sq_r;
  logic [17:0]        alo_r;
  logic [16:0]        h_r [CENTRES];
  logic signed [63:0] acc_r;
  logic signed [31:0] est_r;
  logic signed [32:0] t_r;
  logic signed [31:0] w1_r, wb_r;
  logic signed [33:0] sum_r;
  logic [EAW-1:0]     rom_addr_r;
  logic               h_zero_r;

  // weight memories, one word per joint and centre
  logic signed [31:0] wnow_mem [NW];
  logic signed [31:0] wbef_mem [NW];
  logic signed [31:0] wnow_q, wbef_q;
  logic               mem_we;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic signed [31:0] mem_wn, mem_wb;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wnow_mem[mem_wa] <= mem_wn;
      wbef_mem[mem_wa] <= mem_wb;
    end
    wnow_q <= wnow_mem[mem_ra];
    wbef_q <= wbef_mem[mem_ra];
  end

  assign mem_ra = base_r + AW'(c_r);

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  rbf_mac u_mac (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));

  logic [16:0] rom_q;
  rbf_exp_rom #(.DEPTH(EXP_DEPTH)) u_rom (.clk(clk), .addr(rom_addr_r), .data(rom_q));

  // activation from the table, zero beyond its range
  logic [16:0] h_new;
  assign h_new = h_zero_r ? 17'd0 : rom_q;

  // centre constants for the current centre
  logic signed [32:0] cp_sel, cv_sel;
  always_comb begin
    cp_sel = '0;
    cv_sel = '0;
    for (int c = 0; c < CENTRES; c++) begin
      if (c_r == CW'(c)) begin
        cp_sel = 33'(rbf_pkg::centre_pos(c));
        cv_sel = 33'(rbf_pkg::centre_vel(c));
      end
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
    return (v + 66'sd32768) >>> 16;
  endfunction

  logic [33:0] adx, ady;
  assign adx = dx_r[32] ? 34'(-dx_r) : 34'(dx_r);
  assign ady = dy_r[32] ? 34'(-dy_r) : 34'(dy_r);

  logic signed [65:0] hsel;
  always_comb begin
    hsel = '0;
    for (int c = 0; c < CENTRES; c++) if (c_r == CW'(c)) hsel = 66'(h_r[c]);
  end

  logic last_c;
  assign last_c = (c_r == CW'(CENTRES - 1));
  logic [65:0] sqx_part;
  logic [65:0] a_full;
  assign sqx_part = 66'(prod) >> 16;
  // argument: high part product plus the shifted low part product
  assign a_full = 66'(prod) + 66'(alo_r);

  logic signed [32:0] err_w;
  assign err_w = 33'(tgt_r) - 33'(est_r);

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQX:  begin mul_a = 33'(adx[32:0]); mul_b = 33'(adx[32:0]); end
      S_SQY:  begin mul_a = 33'(ady[32:0]); mul_b = 33'(ady[32:0]); end
      S_ARG2: begin
        mul_a = 33'(sq_r[15:0]);
        mul_b = 33'(inv_width_r[joint_r]);
      end
      S_ARG3: begin
        mul_a = 33'(sq_r[40:16]);
        mul_b = 33'(inv_width_r[joint_r]);
      end
      S_DOT:  begin mul_a = 33'(wnow_q); mul_b = 33'(h_new); end
      S_ERR:  begin mul_a = err_w; mul_b = 33'(learn_rate_r); end
      S_UDW:  begin mul_a = t_r; mul_b = 33'(hsel); end
      S_UM, S_UM2: begin mul_a = 33'(w1_r) - 33'(wb_r); mul_b = 33'(momentum_r); end
      default: ;
    endcase
  end

  // the square products of 33-bit magnitudes can reach 66 bits; split add below
  logic [65:0] sqx_r;
  logic        in_hs, out_hs;
  assign in_hs = in_ch.valid && in_ch.ready;
  assign out_hs = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.estimate = est_r;
  assign out_ch.joint_out = joint_r;

  logic [66:0] sq_sum;
  assign sq_sum = 67'(sqx_r) + 67'(sqx_part);

  logic signed [65:0] upd_sum;
  assign upd_sum = 66'(w1_r) + 66'(sum_r) + rnd16(prod);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == AW'(NW - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_hs) state_nxt = S_DX;
      S_DX:    state_nxt = (int'(joint_r) >= JOINTS || int'(joint_r) >= rbf_pkg::WIDTH_REGS)
                           ? S_OUT : S_DY;
      S_DY:    state_nxt = S_SQX;
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_ARG;
      S_ARG:   state_nxt = S_ARG2;
      S_ARG2:  state_nxt = S_ARG3;
      S_ARG3:  state_nxt = S_ROM;
      S_ROM:   state_nxt = S_RDW;
      S_RDW:   state_nxt = S_DOT;
      S_DOT:   state_nxt = S_DOT2;
      S_DOT2:  state_nxt = last_c ? S_EST : S_DY;
      S_EST:   state_nxt = S_ERR;
      S_ERR:   state_nxt = S_ERR2;
      S_ERR2:  state_nxt = S_URD;
      S_URD:   state_nxt = S_UW;
      S_UW:    state_nxt = S_UDW;
      S_UDW:   state_nxt = S_UDW2;
      S_UDW2:  state_nxt = S_UM;
      S_UM:    state_nxt = S_UM2;
      S_UM2:   state_nxt = S_UWR;
      S_UWR:   state_nxt = last_c ? S_OUT : S_URD;
      S_OUT:   if (out_hs) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_r;
    mem_wn = '0;
    mem_wb = '0;
    if (state_r == S_CLEAR) mem_we = 1'b1;
    else if (state_r == S_UWR) begin
      mem_we = 1'b1;
      mem_wa = mem_ra;
      mem_wn = sat32(upd_sum);
      mem_wb = w1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        joint_r <= in_ch.joint_index;
        pos_r <= in_ch.position;
        vel_r <= in_ch.velocity;
        tgt_r <= in_ch.target_torque;
        c_r <= '0;
        acc_r <= '0;
        est_r <= '0;
        base_r <= AW'(in_ch.joint_index * CENTRES);
      end
      S_DY: begin
        dx_r <= 33'(pos_r) - cp_sel;
        dy_r <= 33'(vel_r) - cv_sel;
      end
      S_SQY: sqx_r <= sqx_part;
      S_ARG: sq_r <= (sq_sum > 67'(66'd1 << 40)) ? 41'(66'd1 << 40) : 41'(sq_sum);
      // low 16 bits of sq times width, already brought back to Q16
      S_ARG3: alo_r <= 18'(sqx_part);
      S_ROM: begin
        h_zero_r <= (a_full >= 66'(rbf_pkg::EXP_RANGE << 16));
        rom_addr_r <= EAW'(a_full >> IDXSH);
      end
      S_DOT: for (int c = 0; c < CENTRES; c++)
               if (c_r == CW'(c)) h_r[c] <= h_new;
      S_DOT2: begin
        acc_r <= acc_r + 64'(prod);
        c_r <= last_c ? '0 : c_r + CW'(1);
      end
      S_EST: est_r <= sat32(rnd16(66'(acc_r)));
      S_ERR2: t_r <= 33'(rnd16(prod));
      S_UW: begin w1_r <= wnow_q; wb_r <= wbef_q; end
      S_UDW2: sum_r <= 34'(rnd16(prod));
      S_UWR: c_r <= last_c ? '0 : c_r + CW'(1);
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
  a_hold_est: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.estimate)) else $error("estimate moved");
  a_clear_blocks: assert property (@(posedge clk)
    state_r == S_CLEAR |-> !in_ch.ready) else $error("ready during clear");
`endif
endmodule
`default_nettype wire

// ===== src/rbf_exp_rom.sv =====
// rbf_exp_rom: registered exp table, Q1.16 entries
// depends on rbf_pkg
`default_nettype none
module rbf_exp_rom #(
  parameter int DEPTH = rbf_pkg::EXP_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  output logic [16:0]                   data
);
  localparam longint RATIO = rbf_pkg::exp_ratio(DEPTH);

  typedef logic [16:0] rom_t [DEPTH];

  function automatic rom_t build();
    rom_t   r;
    longint p;
    p = longint'(1) <<< 30;
    for (int k = 0; k < DEPTH; k++) begin
      r[k] = 17'(rbf_pkg::shr_round(p, 14));
      p = rbf_pkg::shr_round(p * RATIO, 30);
    end
    return r;
  endfunction

  localparam rom_t ROM = build();

  // registered read
  always_ff @(posedge clk) begin
    data <= ROM[addr];
  end
endmodule
`default_nettype wire

// ===== src/rbf_mac.sv =====
// rbf_mac: shared 33x33 signed multiplier with registered product
// no dependencies
`default_nettype none
module rbf_mac (
  input  wire logic               clk,
  input  wire logic signed [32:0] op_a,
  input  wire logic signed [32:0] op_b,
  output logic signed [65:0]      prod
);
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: directed and randomized regression of the rbf torque estimator against a built-in predictor
// depends on rbf_pkg, rbf_stream_if and rbf_network_torque_estimator
`default_nettype none
module testbench;

  localparam int NJ = 6;
  localparam int NC = 5;
  localparam int TAB_DEPTH = 1024;
  localparam int IDX_W = rbf_pkg::CFG_IDX_W;
  localparam int DATA_W = rbf_pkg::CFG_DATA_W;

  typedef struct {
    logic [2:0] joint;
    rbf_pkg::q16_t pos;
    rbf_pkg::q16_t vel;
    rbf_pkg::q16_t tgt;
  } sample_t;

  typedef struct {
    rbf_pkg::q16_t est;
    logic [2:0] joint;
  } estimate_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  rbf_in_if in_ch ();
  rbf_out_if out_ch ();

  rbf_network_torque_estimator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  longint w_now [NJ*NC];
  longint w_prev [NJ*NC];
  longint gain_learn;
  longint gain_mom;
  longint inv_w [NJ];
  longint exp_tab [TAB_DEPTH];
  longint cpos [NC];
  longint cvel [NC];

  sample_t pend_samples[$];
  estimate_t est_queue[$];
  int errors = 0;
  bit in_taken = 0;
  int send_gap = 0;
  int hold_req = 0;
  int hold_left = 0;

  // round(n/d), half toward plus infinity
  function automatic longint rdiv(input longint n, input longint d);
    longint num;
    longint den;
    num = 2 * n + d;
    den = 2 * d;
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // round(v / 2^sh), half toward plus infinity
  function automatic longint rshift(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exp table, centre positions and centre velocities
  task automatic build_tables();
    longint x;
    longint term;
    longint ratio;
    longint p;
    x = rdiv(longint'(16) <<< 30, TAB_DEPTH);
    term = longint'(1) <<< 30;
    ratio = term;
    for (int n = 1; n <= 24; n++) begin
      term = rshift(term * x, 30);
      term = rdiv(term, n);
      ratio = (n % 2 == 1) ? ratio - term : ratio + term;
    end
    p = longint'(1) <<< 30;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      exp_tab[k] = rshift(p, 14);
      p = rshift(p * ratio, 30);
    end
    for (int c = 0; c < NC; c++) begin
      cpos[c] = rdiv(longint'(2 * c - 5) * 1081344, 5);
      cvel[c] = rdiv(longint'(c - 2) * 2162688, 25);
    end
  endtask

  task automatic reset_model();
    gain_learn = rbf_pkg::LEARN_RATE_RST;
    gain_mom = rbf_pkg::MOMENTUM_RST;
    for (int j = 0; j < NJ; j++) inv_w[j] = rbf_pkg::width_reset(j);
    for (int i = 0; i < NJ*NC; i++) begin
      w_now[i] = 0;
      w_prev[i] = 0;
    end
  endtask

  // estimate for one sample, then the momentum weight update; a joint out of range gives zero
  function automatic estimate_t estimate_and_learn(input sample_t s);
    estimate_t r;
    longint act [NC];
    longint acc;
    longint est;
    longint t;
    longint dx;
    longint dy;
    bit [63:0] ux;
    bit [63:0] uy;
    bit [63:0] sq;
    bit [63:0] arg;
    int k;
    longint w1;
    r.joint = s.joint;
    if (s.joint >= NJ) begin
      r.est = '0;
      return r;
    end
    acc = 0;
    for (int c = 0; c < NC; c++) begin
      dx = longint'(s.pos) - cpos[c];
      dy = longint'(s.vel) - cvel[c];
      ux = dx < 0 ? -dx : dx;
      uy = dy < 0 ? -dy : dy;
      sq = ((ux * ux) >> 16) + ((uy * uy) >> 16);
      if (sq > (64'd1 << 40)) sq = 64'd1 << 40;
      arg = (sq * inv_w[s.joint]) >> 16;
      if (arg >= (64'd16 << 16)) act[c] = 0;
      else act[c] = exp_tab[(arg * TAB_DEPTH) / (64'd16 << 16)];
      acc += w_now[s.joint*NC + c] * act[c];
    end
    est = clamp32(rshift(acc, 16));
    t = rshift((longint'(s.tgt) - est) * gain_learn, 16);
    for (int c = 0; c < NC; c++) begin
      k = s.joint*NC + c;
      w1 = w_now[k];
      w_now[k] = clamp32(w1 + rshift(t * act[c], 16) + rshift((w1 - w_prev[k]) * gain_mom, 16));
      w_prev[k] = w1;
    end
    r.est = rbf_pkg::q16_t'(est);
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic rbf_pkg::q16_t rand_q(input int span);
    if ($urandom_range(0, 99) < 85)
      return rbf_pkg::q16_t'(int'($urandom_range(0, 2 * span)) - span);
    return rbf_pkg::q16_t'($urandom);
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.joint = ($urandom_range(0, 99) < 5) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    s.pos = rand_q(20 << 16);
    s.vel = rand_q(5 << 16);
    s.tgt = rand_q(50 << 16);
    return s;
  endfunction

  function automatic sample_t mk(input int j, input longint p, input longint v, input longint g);
    sample_t s;
    s.joint = 3'(j);
    s.pos = rbf_pkg::q16_t'(p);
    s.vel = rbf_pkg::q16_t'(v);
    s.tgt = rbf_pkg::q16_t'(g);
    return s;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input longint val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = DATA_W'(val);
    if (idx == rbf_pkg::REG_LEARN_RATE) gain_learn = val & 16'hFFFF;
    else if (idx == rbf_pkg::REG_MOMENTUM) gain_mom = val & 16'hFFFF;
    else inv_w[idx - rbf_pkg::REG_WIDTH0] = val & 18'h3FFFF;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input longint lr, input longint mom, input longint wd[NJ]);
    write_reg(rbf_pkg::REG_LEARN_RATE, lr);
    write_reg(rbf_pkg::REG_MOMENTUM, mom);
    for (int j = 0; j < NJ; j++) write_reg(rbf_pkg::REG_WIDTH0 + IDX_W'(j), wd[j]);
  endtask

  task automatic drain();
    wait (pend_samples.size() == 0 && !in_ch.valid && est_queue.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_taken || !in_ch.valid) begin
      in_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pend_samples.size() > 0) begin
        sample_t s;
        s = pend_samples.pop_front();
        in_ch.joint_index <= s.joint;
        in_ch.position <= s.pos;
        in_ch.velocity <= s.vel;
        in_ch.target_torque <= s.tgt;
        in_ch.valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver stalls, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      if ($urandom_range(0, 99) < 5) hold_left = $urandom_range(10, 60);
    end
  end

  // accepted inputs feed the predictor, accepted results are checked
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sample_t s;
      s.joint = in_ch.joint_index;
      s.pos = in_ch.position;
      s.vel = in_ch.velocity;
      s.tgt = in_ch.target_torque;
      est_queue.push_back(estimate_and_learn(s));
      in_taken = 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (est_queue.size() == 0) begin
        report("unexpected transaction", out_ch.estimate, 0);
      end else begin
        estimate_t e;
        e = est_queue.pop_front();
        if (out_ch.estimate !== e.est) report("estimate", out_ch.estimate, e.est);
        if (out_ch.joint_out !== e.joint) report("joint_out", out_ch.joint_out, e.joint);
      end
    end
  end

  // run limit
  initial begin
    #30000000;
    $display("rbf_network_torque_estimator regression: fail");
    $finish;
  end

  // stimulus
  initial begin
    longint wd [NJ];
    in_ch.valid = 1'b0;
    in_ch.joint_index = '0;
    in_ch.position = '0;
    in_ch.velocity = '0;
    in_ch.target_torque = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    build_tables();
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: centres, extremes, far arguments, joints out of range
    for (int j = 0; j < 6; j++) pend_samples.push_back(mk(j, cpos[j % NC], cvel[j % NC], 10 << 16));
    pend_samples.push_back(mk(6, 0, 0, 5 << 16));
    pend_samples.push_back(mk(7, -1, -1, -1));
    pend_samples.push_back(mk(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    pend_samples.push_back(mk(1, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648));
    pend_samples.push_back(mk(2, 40 << 16, 0, 3 << 16));
    pend_samples.push_back(mk(5, 3 << 16, 1 << 16, -(7 << 16)));
    pend_samples.push_back(mk(3, 0, 0, 32'h7FFFFFFF));
    pend_samples.push_back(mk(3, 0, 0, -64'sd2147483648));
    pend_samples.push_back(mk(4, 1 << 16, -(1 << 16), 0));
    for (int i = 0; i < 6; i++) pend_samples.push_back(mk(0, cpos[2], cvel[2], 32'h7FFFFFFF));
    drain();

    // extreme register values, then zero widths (all activations one)
    for (int j = 0; j < NJ; j++) wd[j] = 262143;
    configure(65535, 65535, wd);
    for (int i = 0; i < 120; i++) pend_samples.push_back(rand_sample());
    drain();
    for (int j = 0; j < NJ; j++) wd[j] = 0;
    configure(0, 0, wd);
    for (int i = 0; i < 60; i++) pend_samples.push_back(rand_sample());
    drain();
    configure(65535, 0, wd);
    for (int i = 0; i < 120; i++) pend_samples.push_back(rand_sample());
    drain();

    // random settings, one with a long receiver hold-off
    for (int ph = 0; ph < 5; ph++) begin
      for (int j = 0; j < NJ; j++)
        wd[j] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 262143) : $urandom_range(2000, 90000);
      configure($urandom_range(0, 65535), $urandom_range(0, 65535), wd);
      if (ph == 1) hold_req = 2000;
      for (int i = 0; i < 220; i++) pend_samples.push_back(rand_sample());
      drain();
    end

    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("rbf_network_torque_estimator regression: pass");
    end else begin
      $display("rbf_network_torque_estimator regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/rbf_pkg.sv
src/rbf_stream_if.sv
src/rbf_exp_rom.sv
src/rbf_mac.sv
src/rbf_network_torque_estimator.sv
tb/testbench.sv
